FILE: design/nrgs_pkg.sv
// ----------------------------------------------------------------------------
// nrgs_pkg
// Shared types, sizes and ring pointer helpers for the nearest greater stack.
// ----------------------------------------------------------------------------
package nrgs_pkg;

    // sizes
    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int IN_VAL_W    = 16;
    localparam int POS_W       = 10;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = VALUE_WIDTH + POS_W;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    // memory port request
    typedef struct packed {
        logic               re;
        logic [PTR_W-1:0]   raddr;
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
    } t_ram_req;

    // one result beat
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] border;
        logic             overflow;
    } t_res;

    // ring step down
    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == '0) ? PTR_W'(STACK_DEPTH - 1) : p - 1'b1;
        return r;
    endfunction

    // ring step up
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(STACK_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

endpackage

FILE: design/nrgs_ram.sv
// ----------------------------------------------------------------------------
// nrgs_ram
// Generic simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module nrgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/nrgs_ctrl.sv
// ----------------------------------------------------------------------------
// nrgs_ctrl
// Stack sequencer: reads the top entry, pops smaller entries one per cycle,
// then writes the new entry and hands the result to the output register.
// ----------------------------------------------------------------------------
module nrgs_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [nrgs_pkg::IN_VAL_W-1:0]   i_value,
    input  logic [nrgs_pkg::POS_W-1:0]      i_position,
    input  logic                            i_restart,
    output logic                            o_in_stall,
    input  logic                            i_res_free,
    output logic                            o_res_load,
    output nrgs_pkg::t_res                  o_res,
    output nrgs_pkg::t_ram_req              o_ram,
    input  logic [nrgs_pkg::ENTRY_W-1:0]    i_rdata
);

    nrgs_pkg::t_state                   r_state, n_state;
    logic [nrgs_pkg::PTR_W-1:0]         r_top, n_top;
    logic [nrgs_pkg::CNT_W-1:0]         r_count, n_count;
    logic [nrgs_pkg::VALUE_WIDTH-1:0]   r_val, n_val;
    logic [nrgs_pkg::POS_W-1:0]         r_pos, n_pos;
    logic                               r_found, n_found;
    logic [nrgs_pkg::POS_W-1:0]         r_border, n_border;

    logic [nrgs_pkg::VALUE_WIDTH-1:0]   w_rd_val;
    logic [nrgs_pkg::POS_W-1:0]         w_rd_pos;
    logic                               w_push;
    logic [nrgs_pkg::PTR_W-1:0]         w_ptop;
    logic [nrgs_pkg::CNT_W-1:0]         w_pcnt;
    logic                               w_pfound;
    logic [nrgs_pkg::POS_W-1:0]         w_pborder;

    // fields of the entry read back
    assign w_rd_val = i_rdata[nrgs_pkg::POS_W +: nrgs_pkg::VALUE_WIDTH];
    assign w_rd_pos = i_rdata[nrgs_pkg::POS_W-1:0];

    assign o_in_stall = (r_state != nrgs_pkg::S_IDLE);

    // next state, pop and push decisions
    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_count   = r_count;
        n_val     = r_val;
        n_pos     = r_pos;
        n_found   = r_found;
        n_border  = r_border;
        w_push    = 1'b0;
        w_ptop    = r_top;
        w_pcnt    = r_count;
        w_pfound  = r_found;
        w_pborder = r_border;
        o_ram.re    = 1'b0;
        o_ram.raddr = nrgs_pkg::ptr_prev(r_top);

        unique case (r_state)
            nrgs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_val = i_value[nrgs_pkg::VALUE_WIDTH-1:0];
                    n_pos = i_position;
                    if (i_restart || (r_count == '0)) begin
                        // empty stack: nothing to compare
                        if (i_restart) begin
                            n_top   = '0;
                            n_count = '0;
                        end
                        n_found  = 1'b0;
                        n_border = '0;
                        n_state  = nrgs_pkg::S_PUSH;
                    end else begin
                        o_ram.re = 1'b1;
                        n_state  = nrgs_pkg::S_CMP;
                    end
                end
            end
            nrgs_pkg::S_CMP: begin
                if (w_rd_val >= r_val) begin
                    // not-smaller entry stays on top
                    w_pfound  = 1'b1;
                    w_pborder = w_rd_pos;
                    w_push    = 1'b1;
                end else begin
                    // pop one entry
                    w_ptop = nrgs_pkg::ptr_prev(r_top);
                    w_pcnt = r_count - 1'b1;
                    if (r_count == nrgs_pkg::CNT_W'(1)) begin
                        w_pfound  = 1'b0;
                        w_pborder = '0;
                        w_push    = 1'b1;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = nrgs_pkg::ptr_prev(w_ptop);
                    end
                end
                n_top    = w_ptop;
                n_count  = w_pcnt;
                n_found  = w_pfound;
                n_border = w_pborder;
                if (w_push) begin
                    n_state = nrgs_pkg::S_PUSH;
                end
            end
            nrgs_pkg::S_PUSH: begin
                w_push = 1'b1;
            end
            default: begin
                n_state = nrgs_pkg::S_IDLE;
            end
        endcase

        // push completes when the output register can take the beat
        o_res_load = w_push && i_res_free;
        if (o_res_load) begin
            n_top = nrgs_pkg::ptr_next(w_ptop);
            if (w_pcnt != nrgs_pkg::CNT_W'(nrgs_pkg::STACK_DEPTH)) begin
                n_count = w_pcnt + 1'b1;
            end
            n_state = nrgs_pkg::S_IDLE;
        end

        // memory write and result beat
        o_ram.we       = o_res_load;
        o_ram.waddr    = w_ptop;
        o_ram.wdata    = {r_val, r_pos};
        o_res.found    = w_pfound;
        o_res.border   = w_pborder;
        o_res.overflow = (w_pcnt == nrgs_pkg::CNT_W'(nrgs_pkg::STACK_DEPTH));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrgs_pkg::S_IDLE;
            r_top   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_count <= n_count;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_border <= n_border;
    end

endmodule

FILE: design/nearest_greater_stack.sv
// ----------------------------------------------------------------------------
// nearest_greater_stack
// Streaming nearest-greater-value engine on a monotonic stack kept in RAM.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries value, position and a
// restart flag that empties the stack first. Output channel (o_out_valid /
// i_out_stall) returns one beat per item: found, the border position of the
// nearest earlier not-smaller value, and overflow when the push displaced
// the oldest entry of a full stack.
// An item reads the top entry on acceptance, then compares and pops one
// entry at a time until a not-smaller entry or an empty stack ends the pops:
// the stack memory has one read port with a registered read, and each
// compare waits on a read. Items that find an empty stack (or restart) skip
// the compare. One item is in work at a time; the input is stalled while it runs.
// The result sits in an output register, so the next item is taken while a
// finished beat waits. If the receiver stalls, the block holds the next
// result in its controller until the register frees.
// Synchronous reset empties the stack and the output register; the stack
// memory is not cleared, entries are read only after being written.
// ----------------------------------------------------------------------------
module nearest_greater_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nrgs_pkg::IN_VAL_W-1:0] i_value,
    input  logic [nrgs_pkg::POS_W-1:0]    i_position,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [nrgs_pkg::POS_W-1:0]    o_border_position,
    output logic                          o_overflow
);

    nrgs_pkg::t_ram_req                w_ram;
    nrgs_pkg::t_res                    w_res;
    logic                              w_res_load;
    logic                              w_res_free;
    logic [nrgs_pkg::ENTRY_W-1:0]      w_rdata;

    logic                              r_out_valid;
    logic                              r_found;
    logic [nrgs_pkg::POS_W-1:0]        r_border;
    logic                              r_overflow;

    // stack store: value and position per entry
    nrgs_ram #(
        .WIDTH (nrgs_pkg::ENTRY_W),
        .DEPTH (nrgs_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    nrgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_value    (i_value),
        .i_position (i_position),
        .i_restart  (i_restart),
        .o_in_stall (o_in_stall),
        .i_res_free (w_res_free),
        .o_res_load (w_res_load),
        .o_res      (w_res),
        .o_ram      (w_ram),
        .i_rdata    (w_rdata)
    );

    // output register frees when empty or being taken
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_found    <= w_res.found;
            r_border   <= w_res.border;
            r_overflow <= w_res.overflow;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_border_position = r_border;
    assign o_overflow        = r_overflow;

    // a result is never loaded over a beat still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> w_res_free)
        else $error("result loaded over a stalled beat");

    // an accepted item keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    // the stack memory never reads and writes in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram.we && w_ram.re))
        else $error("stack read and write overlap");

    // not found always reports a zero border
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && !w_res.found) |-> (w_res.border == '0))
        else $error("border set without a found entry");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_greater_stack. A model of the monotonic
// stack in the bench predicts found, border position and overflow for each
// accepted beat. Results are checked in order against those predictions.
// Stimulus covers corner values, forward and reversed sequences with
// restarts, ring wrap on a full stack and noise, under random idling on both
// channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = nrgs_pkg::STACK_DEPTH;
    localparam int VW           = nrgs_pkg::VALUE_WIDTH;
    localparam int RUN_LIMIT    = 500_000;
    localparam int DRAIN_CYCLES = 32;

    // dut connections
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [nrgs_pkg::IN_VAL_W-1:0] i_value;
    logic [nrgs_pkg::POS_W-1:0]    i_position;
    logic                          i_restart;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_found;
    logic [nrgs_pkg::POS_W-1:0]    o_border_position;
    logic                          o_overflow;

    // bench copy of the stack
    logic [VW-1:0]                 stk_val [DEPTH];
    logic [nrgs_pkg::POS_W-1:0]    stk_pos [DEPTH];
    int unsigned                   stk_count;
    int unsigned                   stk_top;

    // expected border results, oldest first
    nrgs_pkg::t_res                border_q[$];
    nrgs_pkg::t_res                exp_res;

    int                            gap_pct   = 0;
    int                            stall_pct = 0;
    int                            n_errors  = 0;
    int unsigned                   n_cycles  = 0;

    nearest_greater_stack i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_value           (i_value),
        .i_position        (i_position),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_found           (o_found),
        .o_border_position (o_border_position),
        .o_overflow        (o_overflow)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > RUN_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // pop, compare and push one beat on the bench stack
    function automatic nrgs_pkg::t_res predict_border(
        input logic [nrgs_pkg::IN_VAL_W-1:0] value,
        input logic [nrgs_pkg::POS_W-1:0]    position,
        input logic                          restart
    );
        nrgs_pkg::t_res res;
        logic [VW-1:0]  v;
        int unsigned    below;
        bit             halted;
        v      = value[VW-1:0];
        res    = '0;
        halted = 1'b0;
        if (restart) begin
            stk_count = 0;
            stk_top   = 0;
        end
        // drop every entry strictly smaller than the new value
        while (stk_count > 0 && !halted) begin
            below = (stk_top == 0) ? DEPTH - 1 : stk_top - 1;
            if (stk_val[below] >= v) begin
                halted = 1'b1;
            end else begin
                stk_top = below;
                stk_count--;
            end
        end
        if (stk_count > 0) begin
            res.found  = 1'b1;
            res.border = stk_pos[(stk_top == 0) ? DEPTH - 1 : stk_top - 1];
        end
        // push, overwriting the oldest entry when full
        stk_val[stk_top] = v;
        stk_pos[stk_top] = position;
        stk_top = (stk_top == DEPTH - 1) ? 0 : stk_top + 1;
        if (stk_count < DEPTH) begin
            stk_count++;
        end else begin
            res.overflow = 1'b1;
        end
        return res;
    endfunction

    // offer one beat, hold it until taken, then record its expectation
    task automatic send_item(
        input logic [nrgs_pkg::IN_VAL_W-1:0] value,
        input logic [nrgs_pkg::POS_W-1:0]    position,
        input logic                          restart
    );
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_value    = value;
        i_position = position;
        i_restart  = restart;
        do @(posedge i_clk); while (o_in_stall);
        border_q.push_back(predict_border(value, position, restart));
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (border_q.size() == 0) begin
                $display("%0t: unexpected beat: found %0b border %0d overflow %0b",
                         $time, o_found, o_border_position, o_overflow);
                n_errors++;
            end else begin
                exp_res = border_q.pop_front();
                if (o_found !== exp_res.found) begin
                    $display("%0t: found mismatch: expected %0b, got %0b",
                             $time, exp_res.found, o_found);
                    n_errors++;
                end
                if (o_border_position !== exp_res.border) begin
                    $display("%0t: border mismatch: expected %0d, got %0d",
                             $time, exp_res.border, o_border_position);
                    n_errors++;
                end
                if (o_overflow !== exp_res.overflow) begin
                    $display("%0t: overflow mismatch: expected %0b, got %0b",
                             $time, exp_res.overflow, o_overflow);
                    n_errors++;
                end
            end
        end
    end

    // corner values, equal values, full pops and restarts
    task automatic test_directed_extremes();
        send_item(16'h1234, 10'd5,    1'b0);
        send_item(16'h1234, 10'd6,    1'b0);
        send_item(16'h0000, 10'd0,    1'b0);
        send_item(16'hFFFF, 10'd1023, 1'b0);
        send_item(16'hFFFF, 10'd1022, 1'b0);
        send_item(16'h8000, 10'd512,  1'b0);
        send_item(16'h7FFF, 10'd511,  1'b0);
        send_item(16'h8001, 10'd513,  1'b0);
        send_item(16'h0001, 10'd1,    1'b1);
        send_item(16'h0000, 10'd2,    1'b0);
        send_item(16'h0002, 10'd3,    1'b0);
        send_item(16'hAAAA, 10'h2AA,  1'b0);
        send_item(16'h5555, 10'h155,  1'b0);
        send_item(16'h5555, 10'h2AA,  1'b0);
        send_item(16'hFFFF, 10'h3FF,  1'b1);
        send_item(16'h0000, 10'h000,  1'b0);
        send_item(16'h0000, 10'h3FF,  1'b0);
        send_item(16'h0000, 10'h000,  1'b1);
        send_item(16'hFFFF, 10'h155,  1'b0);
        send_item(16'hFFFE, 10'h3FE,  1'b0);
    endtask

    // long non-increasing run fills the ring, then pops cross the seam
    task automatic test_ring_overflow();
        int level;
        level = 65535;
        for (int i = 0; i < DEPTH + 76; i++) begin
            send_item(level[15:0], i[9:0], i == 0);
            level -= $urandom_range(0, 100);
            if (level < 0) level = 0;
        end
        for (int i = 0; i < 40; i++) begin
            send_item(16'($urandom), 10'($urandom), 1'b0);
        end
        send_item(16'hFFFF, 10'h3FF, 1'b0);
    endtask

    // sequences fed forward then reversed, with some noise segments
    task automatic test_random_sequences(input int n_items);
        logic [15:0] seq [256];
        int          sent;
        int          len;
        int          shape;
        int          level;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 256)
                                                 : $urandom_range(1, 64);
            shape = $urandom_range(0, 3);
            level = $urandom_range(0, 65535);
            for (int i = 0; i < len; i++) begin
                case (shape)
                    0: seq[i] = 16'($urandom);
                    1: seq[i] = 16'($urandom_range(0, 3) * 16'h5555);
                    2: begin
                        level -= $urandom_range(0, 400);
                        if (level < 0) level = 0;
                        seq[i] = level[15:0];
                    end
                    default: begin
                        level += $urandom_range(0, 600) - 200;
                        if (level < 0) level = 0;
                        if (level > 65535) level = 65535;
                        seq[i] = level[15:0];
                    end
                endcase
            end
            if ($urandom_range(0, 9) < 8) begin
                // left borders, then right borders
                for (int i = 0; i < len; i++) begin
                    send_item(seq[i], i[9:0], i == 0);
                end
                for (int i = len - 1; i >= 0; i--) begin
                    send_item(seq[i], i[9:0], i == len - 1);
                end
                sent += 2 * len;
            end else begin
                // noise: stray restarts and arbitrary positions
                for (int i = 0; i < len; i++) begin
                    send_item(seq[i], 10'($urandom), $urandom_range(0, 7) == 0);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_value    = '0;
        i_position = '0;
        i_restart  = 1'b0;
        stk_count  = 0;
        stk_top    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender mostly busy, receiver mostly stalling
        gap_pct   = 10;
        stall_pct = 87;
        test_directed_extremes();
        test_random_sequences(300);

        // sender mostly idle, receiver mostly ready
        gap_pct   = 87;
        stall_pct = 10;
        test_random_sequences(300);

        // full rate both ways
        gap_pct   = 0;
        stall_pct = 0;
        test_ring_overflow();
        test_random_sequences(250);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (border_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
